FILE: hdl/fsc_pkg.sv
// Shared types and constants for the flood sync slot controller.
package fsc_pkg;

  // Event codes carried in the action field.
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_RX     = 2'd1;
  localparam logic [1:0] ACT_PREP   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // Register indexes on the configuration port (byte address bits [3:2]).
  localparam logic [1:0] REG_TRANSMIT_COUNT = 2'd0;
  localparam logic [1:0] REG_SLOT_LENGTH    = 2'd1;
  localparam logic [1:0] REG_GUARD          = 2'd2;
  localparam logic [1:0] REG_RX_OFFSET      = 2'd3;

  // Register reset values.
  localparam logic [6:0]  TRANSMIT_COUNT_RST = 7'd3;
  localparam logic [31:0] SLOT_LENGTH_RST    = 32'd1000;
  localparam logic [31:0] GUARD_RST          = 32'd100;
  localparam logic [31:0] RX_OFFSET_RST      = 32'd0;

  // Hop count that marks an unknown distance.
  localparam logic [7:0] HOP_UNKNOWN = 8'hFF;

  // One input item.
  typedef struct packed {
    logic [1:0]  action;
    logic        initiator;
    logic [31:0] local_ticks;
    logic [31:0] epoch;
    logic [7:0]  relay_count;
    logic        did_transmit;
  } event_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  tx_relay_count;
    logic [31:0] tx_epoch;
    logic        transmit_flag;
    logic        phase_active;
    logic        has_reference;
    logic        joined;
    logic [7:0]  hop_distance;
    logic [7:0]  slot_index;
    logic [31:0] reference_ticks;
    logic [31:0] next_phase_start_ticks;
    logic [31:0] slot_start_ticks;
  } result_t;

endpackage

FILE: hdl/flood_sync_slot_controller_top.sv
// Flood sync slot controller: sync phase slot tracking with an APB register port.
//
//   Channel  | Direction | Handshake             | Payload
//   event    | in        | event_valid/stall     | fsc_pkg::event_t
//   result   | out       | result_valid/stall    | fsc_pkg::result_t
//   config   | in/out    | APB psel/penable      | four 32-bit registers
//
// Each item passes an input stage that registers the item with the relay
// product (one 8x32 multiply), then the state update that loads the result
// register, with a second 8x32 multiply for the slot start tick. One item is
// accepted per cycle while the event channel is not stalled.
// Reset (rst, synchronous, active high) restores the registers and the state.
// A stalled result holds the result register; the input stage then stalls
// the event channel only when it is occupied.
module flood_sync_slot_controller_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                event_valid,
  output logic                event_stall,
  input  fsc_pkg::event_t     event_item,
  output logic                result_valid,
  input  logic                result_stall,
  output fsc_pkg::result_t    result_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers and the derived phase span.
  logic [6:0]  transmit_count;
  logic [31:0] slot_length_ticks;
  logic [31:0] guard_ticks;
  logic [31:0] rx_stamp_offset_ticks;
  logic [31:0] phase_span;
  logic [7:0]  budget_slots;
  logic [39:0] span_prod;
  logic        cfg_write;

  // Input stage.
  logic            a_valid;
  fsc_pkg::event_t a_item;
  logic [31:0]     a_prod;
  logic [31:0]     a_t0;
  logic [39:0]     relay_prod;
  logic            accept;
  logic            advance;

  // Protocol state.
  logic [7:0]  slot_counter,    slot_counter_next;
  logic        reference_valid, reference_valid_next;
  logic [31:0] reference_time,  reference_time_next;
  logic [31:0] next_phase_time, next_phase_time_next;
  logic [7:0]  hop_count,       hop_count_next;
  logic        send_flag,       send_flag_next;
  logic        running,         running_next;
  logic        joined_flag,     joined_flag_next;
  logic [7:0]  sends_done,      sends_done_next;
  logic [31:0] epoch_value,     epoch_value_next;

  logic [31:0] ref_rx;
  logic [7:0]  relay_inc;
  logic        below_count;
  logic [39:0] slot_prod;

  // Configuration port: writes land on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_count        <= fsc_pkg::TRANSMIT_COUNT_RST;
      slot_length_ticks     <= fsc_pkg::SLOT_LENGTH_RST;
      guard_ticks           <= fsc_pkg::GUARD_RST;
      rx_stamp_offset_ticks <= fsc_pkg::RX_OFFSET_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        fsc_pkg::REG_TRANSMIT_COUNT: transmit_count        <= pwdata[6:0];
        fsc_pkg::REG_SLOT_LENGTH:    slot_length_ticks     <= pwdata;
        fsc_pkg::REG_GUARD:          guard_ticks           <= pwdata;
        fsc_pkg::REG_RX_OFFSET:      rx_stamp_offset_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fsc_pkg::REG_TRANSMIT_COUNT: prdata = {25'd0, transmit_count};
      fsc_pkg::REG_SLOT_LENGTH:    prdata = slot_length_ticks;
      fsc_pkg::REG_GUARD:          prdata = guard_ticks;
      fsc_pkg::REG_RX_OFFSET:      prdata = rx_stamp_offset_ticks;
      default:                     prdata = 32'd0;
    endcase
  end

  // Length of the whole sync phase plus guard, kept in a register.
  assign budget_slots = {transmit_count, 1'b0};
  assign span_prod    = {32'd0, budget_slots} * {8'd0, slot_length_ticks};

  always_ff @(posedge clk) begin
    phase_span <= span_prod[31:0] + guard_ticks;
  end

  // Handshake: the result register frees when empty or taken.
  assign advance     = a_valid && (!result_valid || !result_stall);
  assign event_stall = a_valid && result_valid && result_stall;
  assign accept      = event_valid && !event_stall;

  // Input stage registers the item with the relay product and offset.
  assign relay_prod = {32'd0, event_item.relay_count} * {8'd0, slot_length_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= event_item;
      a_prod <= relay_prod[31:0];
      a_t0   <= event_item.local_ticks - rx_stamp_offset_ticks;
    end
  end

  // State update for the item in the input stage.
  assign ref_rx      = a_t0 - a_prod;
  assign relay_inc   = a_item.relay_count + 8'd1;
  assign below_count = sends_done < {1'b0, transmit_count};

  always_comb begin
    slot_counter_next    = slot_counter;
    reference_valid_next = reference_valid;
    reference_time_next  = reference_time;
    next_phase_time_next = next_phase_time;
    hop_count_next       = hop_count;
    send_flag_next       = send_flag;
    running_next         = running;
    joined_flag_next     = joined_flag;
    sends_done_next      = sends_done;
    epoch_value_next     = epoch_value;
    case (a_item.action)
      fsc_pkg::ACT_START: begin
        slot_counter_next    = 8'd0;
        sends_done_next      = 8'd0;
        reference_valid_next = a_item.initiator;
        reference_time_next  = a_item.initiator ? a_item.local_ticks : 32'd0;
        next_phase_time_next = a_item.initiator ? a_item.local_ticks + phase_span : 32'd0;
        joined_flag_next     = a_item.initiator;
        epoch_value_next     = a_item.epoch;
        running_next         = 1'b1;
        send_flag_next       = a_item.initiator;
        hop_count_next       = a_item.initiator ? 8'd0 : fsc_pkg::HOP_UNKNOWN;
      end
      fsc_pkg::ACT_RX: begin
        epoch_value_next = a_item.epoch;
        if (!reference_valid) begin
          // First frame: work back from the receive stamp to slot zero.
          reference_valid_next = 1'b1;
          reference_time_next  = ref_rx;
          next_phase_time_next = ref_rx + phase_span;
          hop_count_next       = relay_inc;
          joined_flag_next     = 1'b1;
          slot_counter_next    = relay_inc;
          send_flag_next       = below_count;
        end else if (a_item.relay_count > slot_counter) begin
          slot_counter_next = a_item.relay_count;
        end
      end
      fsc_pkg::ACT_PREP: begin
        if (sends_done != 8'hFF) begin
          sends_done_next = sends_done + 8'd1;
        end
      end
      fsc_pkg::ACT_FINISH: begin
        if (running) begin
          send_flag_next    = !a_item.did_transmit && reference_valid && below_count;
          slot_counter_next = slot_counter + 8'd1;
          if (slot_counter_next >= budget_slots) begin
            running_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Offset of the current slot from the reference.
  assign slot_prod = {32'd0, slot_counter_next} * {8'd0, slot_length_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter    <= 8'd0;
      reference_valid <= 1'b0;
      reference_time  <= 32'd0;
      next_phase_time <= 32'd0;
      hop_count       <= fsc_pkg::HOP_UNKNOWN;
      send_flag       <= 1'b0;
      running         <= 1'b1;
      joined_flag     <= 1'b0;
      sends_done      <= 8'd0;
      epoch_value     <= 32'd0;
    end else if (advance) begin
      slot_counter    <= slot_counter_next;
      reference_valid <= reference_valid_next;
      reference_time  <= reference_time_next;
      next_phase_time <= next_phase_time_next;
      hop_count       <= hop_count_next;
      send_flag       <= send_flag_next;
      running         <= running_next;
      joined_flag     <= joined_flag_next;
      sends_done      <= sends_done_next;
      epoch_value     <= epoch_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item.tx_relay_count         <= slot_counter_next;
      result_item.tx_epoch               <= epoch_value_next;
      result_item.transmit_flag          <= send_flag_next;
      result_item.phase_active           <= running_next;
      result_item.has_reference          <= reference_valid_next;
      result_item.joined                 <= joined_flag_next;
      result_item.hop_distance           <= hop_count_next;
      result_item.slot_index             <= slot_counter_next;
      result_item.reference_ticks        <= reference_time_next;
      result_item.next_phase_start_ticks <= next_phase_time_next;
      result_item.slot_start_ticks       <= reference_valid_next
                                            ? reference_time_next + slot_prod[31:0]
                                            : 32'd0;
    end
  end

endmodule

FILE: bench/fsc_result_checker.sv
// Result checker for the flood sync slot controller: predicts every result item and compares it.
`timescale 1ns / 1ps

module fsc_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             event_valid,
  input  logic             event_stall,
  input  fsc_pkg::event_t  event_item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  fsc_pkg::result_t result_item,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending
);

  // Register copies, updated from the writes seen on the configuration port.
  logic [6:0]  cfg_transmit_count;
  logic [31:0] cfg_slot_length;
  logic [31:0] cfg_guard;
  logic [31:0] cfg_rx_offset;

  // Predicted controller state.
  logic [7:0]  slot_ctr;
  logic        ref_held;
  logic [31:0] ref_time;
  logic [31:0] next_phase;
  logic [7:0]  hops;
  logic        send_next;
  logic        phase_running;
  logic        joined_st;
  logic [7:0]  sends_count;
  logic [31:0] epoch_cur;

  fsc_pkg::result_t expected_results[$];
  int      errors = 0;
  int      reports = 0;
  int      waiting = 0;

  assign fail_count = errors;
  assign pending    = waiting;

  // Restore the register copies and the state to their values after reset.
  task automatic reset_prediction();
    cfg_transmit_count = fsc_pkg::TRANSMIT_COUNT_RST;
    cfg_slot_length    = fsc_pkg::SLOT_LENGTH_RST;
    cfg_guard          = fsc_pkg::GUARD_RST;
    cfg_rx_offset      = fsc_pkg::RX_OFFSET_RST;
    slot_ctr      = '0;
    ref_held      = 1'b0;
    ref_time      = '0;
    next_phase    = '0;
    hops          = fsc_pkg::HOP_UNKNOWN;
    send_next     = 1'b0;
    phase_running = 1'b1;
    joined_st     = 1'b0;
    sends_count   = '0;
    epoch_cur     = '0;
  endtask

  // The next phase begins after the whole slot budget plus the guard time.
  function automatic logic [31:0] phase_end(input logic [31:0] ref_tick);
    logic [7:0]  budget;
    logic [31:0] span;
    budget = {cfg_transmit_count, 1'b0};
    span = budget * cfg_slot_length;
    return ref_tick + span + cfg_guard;
  endfunction

  // Apply one event item to the predicted state and build the result it causes.
  task automatic apply_event(input fsc_pkg::event_t ev, output fsc_pkg::result_t res);
    logic [7:0]  budget;
    logic [31:0] span;
    logic [31:0] new_ref;
    budget = {cfg_transmit_count, 1'b0};
    case (ev.action)
      fsc_pkg::ACT_START: begin
        slot_ctr      = '0;
        sends_count   = '0;
        ref_held      = 1'b0;
        ref_time      = '0;
        next_phase    = '0;
        joined_st     = ev.initiator;
        epoch_cur     = ev.epoch;
        phase_running = 1'b1;
        send_next     = ev.initiator;
        hops          = ev.initiator ? 8'd0 : fsc_pkg::HOP_UNKNOWN;
        if (ev.initiator) begin
          ref_held   = 1'b1;
          ref_time   = ev.local_ticks;
          next_phase = phase_end(ev.local_ticks);
        end
      end
      fsc_pkg::ACT_RX: begin
        epoch_cur = ev.epoch;
        if (!ref_held) begin
          // Work back from the receive stamp to the start of slot zero.
          span       = ev.relay_count * cfg_slot_length;
          new_ref    = ev.local_ticks - cfg_rx_offset - span;
          ref_held   = 1'b1;
          ref_time   = new_ref;
          next_phase = phase_end(new_ref);
          hops       = ev.relay_count + 8'd1;
          joined_st  = 1'b1;
          slot_ctr   = ev.relay_count + 8'd1;
          send_next  = ({1'b0, sends_count} < {2'b00, cfg_transmit_count});
        end else if (ev.relay_count > slot_ctr) begin
          slot_ctr = ev.relay_count;
        end
      end
      fsc_pkg::ACT_PREP: begin
        if (sends_count != 8'hFF) begin
          sends_count = sends_count + 8'd1;
        end
      end
      fsc_pkg::ACT_FINISH: begin
        // A finished slot is ignored once the phase has ended.
        if (phase_running) begin
          send_next = !ev.did_transmit && ref_held &&
                      ({1'b0, sends_count} < {2'b00, cfg_transmit_count});
          slot_ctr = slot_ctr + 8'd1;
          if (slot_ctr >= budget) begin
            phase_running = 1'b0;
          end
        end
      end
      default: ;
    endcase

    span = slot_ctr * cfg_slot_length;
    res.tx_relay_count         = slot_ctr;
    res.tx_epoch               = epoch_cur;
    res.transmit_flag          = send_next;
    res.phase_active           = phase_running;
    res.has_reference          = ref_held;
    res.joined                 = joined_st;
    res.hop_distance           = hops;
    res.slot_index             = slot_ctr;
    res.reference_ticks        = ref_time;
    res.next_phase_start_ticks = next_phase;
    res.slot_start_ticks       = ref_held ? ref_time + span : 32'd0;
  endtask

  // Watch all three ports at each rising edge.
  always @(posedge clk) begin
    fsc_pkg::result_t want;
    fsc_pkg::result_t fresh;
    if (rst) begin
      reset_prediction();
      expected_results.delete();
    end else begin
      // Compare an accepted result item against the oldest expectation.
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (reports < 10) begin
            reports++;
            $display("[%0t] result item with nothing expected: %h", $time, result_item);
          end
        end else begin
          want = expected_results.pop_front();
          if (result_item !== want) begin
            errors++;
            if (reports < 10) begin
              reports++;
              $display("[%0t] result mismatch: expected %h, got %h", $time, want,
                       result_item);
            end
          end
        end
      end

      // Track register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fsc_pkg::REG_TRANSMIT_COUNT: cfg_transmit_count = pwdata[6:0];
          fsc_pkg::REG_SLOT_LENGTH:    cfg_slot_length    = pwdata;
          fsc_pkg::REG_GUARD:          cfg_guard          = pwdata;
          fsc_pkg::REG_RX_OFFSET:      cfg_rx_offset      = pwdata;
          default: ;
        endcase
      end

      // Predict the result of an accepted event item.
      if (event_valid && !event_stall) begin
        apply_event(event_item, fresh);
        expected_results.push_back(fresh);
      end
    end
    waiting = expected_results.size();
  end

endmodule

FILE: bench/flood_sync_slot_controller_top_tb.sv
// Testbench top for the flood sync slot controller: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module flood_sync_slot_controller_top_tb;

  localparam int LIMIT_CYCLES     = 500000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES       = 8;
  localparam int PHASE_ITEMS      = 140;
  localparam int END_WAIT_CYCLES  = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             event_valid = 1'b0;
  logic             event_stall;
  fsc_pkg::event_t  event_item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  fsc_pkg::result_t result_item;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [3:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int phase_items = 0;
  int src_run_left = 0;
  int hold_request = 0;
  bit quiet = 1'b0;
  bit no_gaps = 1'b0;
  logic [6:0] cur_transmit_count = fsc_pkg::TRANSMIT_COUNT_RST;

  flood_sync_slot_controller_top dut (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_stall(event_stall), .event_item(event_item),
    .result_valid(result_valid), .result_stall(result_stall), .result_item(result_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fsc_result_checker result_check (
    .clk(clk), .rst(rst),
    .event_valid(event_valid), .event_stall(event_stall), .event_item(event_item),
    .result_valid(result_valid), .result_stall(result_stall), .result_item(result_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The result receiver stalls in random bursts, holds off once for a long
  // stretch on request, and never stalls in the quiet part of the run.
  initial begin : receiver
    int hold_left;
    int burst_left;
    int run_left;
    hold_left = 0;
    burst_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_stall = 1'b1;
        hold_left--;
      end else if (quiet) begin
        result_stall = 1'b0;
      end else if (burst_left > 0) begin
        result_stall = 1'b1;
        burst_left--;
      end else if (run_left > 0) begin
        result_stall = 1'b0;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        result_stall = 1'b1;
      end else begin
        run_left = $urandom_range(0, 30);
        result_stall = 1'b0;
      end
    end
  end

  function automatic fsc_pkg::event_t make_item(input logic [1:0] act, input logic init,
                                                input logic [31:0] ticks,
                                                input logic [31:0] ep,
                                                input logic [7:0] relay, input logic did);
    fsc_pkg::event_t ev;
    ev.action       = act;
    ev.initiator    = init;
    ev.local_ticks  = ticks;
    ev.epoch        = ep;
    ev.relay_count  = relay;
    ev.did_transmit = did;
    return ev;
  endfunction

  function automatic fsc_pkg::event_t random_item();
    logic [1:0] act;
    act = 2'($urandom_range(0, 3));
    return make_item(act, 1'($urandom_range(0, 1)), $urandom, $urandom,
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one event item, after an optional idle burst, and wait for it to be
  // accepted. Called and returning at a falling edge.
  task automatic send_item(input fsc_pkg::event_t ev);
    if (!quiet && !no_gaps) begin
      if (src_run_left > 0) begin
        src_run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        event_valid = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        src_run_left = $urandom_range(0, 25);
      end
    end
    event_item = ev;
    event_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!event_stall) break;
    end
    @(negedge clk);
    phase_items++;
  endtask

  // Stop offering items until every expected result item has arrived.
  task automatic drain();
    event_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write all registers once the block is idle.
  task automatic set_registers(input logic [6:0] tx, input logic [31:0] slot_len,
                               input logic [31:0] guard, input logic [31:0] offset);
    drain();
    write_reg(fsc_pkg::REG_TRANSMIT_COUNT, {25'd0, tx});
    write_reg(fsc_pkg::REG_SLOT_LENGTH, slot_len);
    write_reg(fsc_pkg::REG_GUARD, guard);
    write_reg(fsc_pkg::REG_RX_OFFSET, offset);
    cur_transmit_count = tx;
  endtask

  // One flood: a start, for a follower the first received frame, then a run
  // of slots with transmits, finishes and the odd later frame.
  task automatic run_flood();
    logic       init;
    logic [7:0] relay;
    logic [31:0] ep;
    int budget;
    int top_relay;
    int slots;
    int pick;
    init = ($urandom_range(0, 3) == 0);
    ep = $urandom;
    budget = 2 * cur_transmit_count;
    top_relay = (budget + 2 > 255) ? 255 : budget + 2;
    send_item(make_item(fsc_pkg::ACT_START, init, $urandom, ep,
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    if (!init) begin
      // Slots can pass before a follower hears the flood.
      repeat ($urandom_range(0, 2)) begin
        send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, $urandom, $urandom,
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 7) == 0) relay = 8'($urandom_range(0, 255));
      else relay = 8'($urandom_range(0, top_relay));
      send_item(make_item(fsc_pkg::ACT_RX, 1'($urandom_range(0, 1)), $urandom, ep, relay,
                          1'($urandom_range(0, 1))));
    end
    slots = (budget + 2 < 40) ? budget + 2 : 40;
    repeat (slots) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_item(make_item(fsc_pkg::ACT_PREP, 1'($urandom_range(0, 1)), $urandom,
                            $urandom, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
        send_item(make_item(fsc_pkg::ACT_FINISH, 1'($urandom_range(0, 1)), $urandom,
                            $urandom, 8'($urandom_range(0, 255)), 1'b1));
      end else if (pick < 9) begin
        send_item(make_item(fsc_pkg::ACT_FINISH, 1'($urandom_range(0, 1)), $urandom,
                            $urandom, 8'($urandom_range(0, 255)),
                            ($urandom_range(0, 7) == 0)));
      end else begin
        relay = 8'($urandom_range(0, top_relay));
        send_item(make_item(fsc_pkg::ACT_RX, 1'($urandom_range(0, 1)), $urandom,
                            ($urandom_range(0, 3) == 0) ? $urandom : ep, relay,
                            1'($urandom_range(0, 1))));
      end
    end
  endtask

  // A few fully random items between floods.
  task automatic run_noise();
    repeat ($urandom_range(1, 8)) send_item(random_item());
  endtask

  // Fill the phase with floods and noise.
  task automatic run_random_part();
    while (phase_items < PHASE_ITEMS) begin
      if ($urandom_range(0, 5) == 0) run_noise();
      else run_flood();
    end
  endtask

  // Directed items at the reset settings.
  task automatic run_directed();
    // A finish before any start, while the phase counts as running.
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_PREP, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    // First frame: the reference wraps below zero.
    send_item(make_item(fsc_pkg::ACT_RX, 1'b0, 32'd5, 32'hFFFF_FFFF, 8'd2, 1'b0));
    // Later frames only move the slot forward.
    send_item(make_item(fsc_pkg::ACT_RX, 1'b0, 32'hFFFF_FFFF, 32'd7, 8'd200, 1'b0));
    send_item(make_item(fsc_pkg::ACT_RX, 1'b0, 32'd0, 32'd8, 8'd1, 1'b0));
    // Initiator start whose next phase time wraps.
    send_item(make_item(fsc_pkg::ACT_START, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b1));
    send_item(make_item(fsc_pkg::ACT_PREP, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b1));
    repeat (5) send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    // Finish after the phase has ended, then a frame while stopped.
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                        1'b0));
    send_item(make_item(fsc_pkg::ACT_RX, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 8'hFF, 1'b1));
    // Follower start, a slot without reference, then relay 255 wrapping the hop count.
    send_item(make_item(fsc_pkg::ACT_START, 1'b0, 32'd0, 32'd1, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_RX, 1'b0, 32'hFFFF_FFFF, 32'd2, 8'hFF, 1'b0));
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_START, 1'b0, 32'd0, 32'd3, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_RX, 1'b0, 32'd0, 32'd3, 8'd0, 1'b0));
    send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
  endtask

  // Main sequence: reset, then one phase per register setting.
  initial begin
    logic [6:0] tx;
    logic [31:0] slot_len;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      phase_items = 0;
      case (phase)
        0: run_directed();
        1: set_registers(7'd0, 32'd0, 32'd0, 32'd0);
        2: begin
          set_registers(7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          // The send counter saturates at 255.
          send_item(make_item(fsc_pkg::ACT_START, 1'b0, $urandom, $urandom, 8'd0, 1'b0));
          repeat (258) begin
            send_item(make_item(fsc_pkg::ACT_PREP, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
          end
          send_item(make_item(fsc_pkg::ACT_RX, 1'b0, $urandom, $urandom, 8'd3, 1'b0));
          send_item(make_item(fsc_pkg::ACT_FINISH, 1'b0, 32'd0, 32'd0, 8'd0, 1'b0));
        end
        default: begin
          if ($urandom_range(0, 5) == 0) tx = 7'($urandom_range(0, 127));
          else tx = 7'($urandom_range(1, 8));
          if ($urandom_range(0, 1) == 0) slot_len = $urandom;
          else slot_len = $urandom_range(0, 5000);
          set_registers(tx, slot_len, $urandom, $urandom);
          if (phase == 3) begin
            // The receiver holds off while items keep coming, so the block fills up.
            hold_request = LONG_HOLD_CYCLES;
            no_gaps = 1'b1;
            run_flood();
            run_flood();
            no_gaps = 1'b0;
          end
          if (phase == NUM_PHASES - 1) quiet = 1'b1;
        end
      endcase
      run_random_part();
    end

    drain();
    repeat (END_WAIT_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: flood_sync_slot_controller_top.f
hdl/fsc_pkg.sv
hdl/flood_sync_slot_controller_top.sv
bench/fsc_result_checker.sv
bench/flood_sync_slot_controller_top_tb.sv
